>>> hw/rtl/lrsf_pkg.sv
// Shared types, constants and helper functions for the label row span fill block.
`timescale 1ns / 1ps
`default_nettype none

package lrsf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    localparam int DIM_W   = 9;
    localparam int LABEL_W = 8;
    localparam int IDX_W   = 1;

    localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);
    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [LABEL_W-1:0] LABEL_ZERO = LABEL_W'(0);
    localparam logic [LABEL_W-1:0] LABEL_MARK = LABEL_W'(2);

    typedef struct packed {
        logic in_span;
        logic last;
    } t_rd_info;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_ONE;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lrsf_ctrl.sv
// Position counters, row span tracking and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module lrsf_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lrsf_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [lrsf_pkg::DIM_W-1:0]    i_cfg_data,
    input  wire logic                          i_accept,
    input  wire logic                          i_action,
    input  wire logic [lrsf_pkg::LABEL_W-1:0]  i_label,
    output logic                               o_we,
    output logic [lrsf_pkg::ADDR_W-1:0]        o_waddr,
    output logic [lrsf_pkg::LABEL_W-1:0]       o_wdata,
    output logic                               o_re,
    output logic [lrsf_pkg::ADDR_W-1:0]        o_raddr,
    output lrsf_pkg::t_rd_info                 o_rd_info
);

    logic [lrsf_pkg::DIM_W-1:0] r_width, n_width, r_height, n_height;
    logic [lrsf_pkg::COL_W-1:0] r_ld_col, n_ld_col, r_rd_col, n_rd_col;
    logic [lrsf_pkg::ROW_W-1:0] r_ld_row, n_ld_row, r_rd_row, n_rd_row;
    logic [lrsf_pkg::ROW_W-1:0] r_span_first, n_span_first, r_span_last, n_span_last;
    logic                       r_marker, n_marker, r_complete, n_complete;

    logic [lrsf_pkg::DIM_W-1:0] w, h;
    logic [lrsf_pkg::COL_W-1:0] ld_col_b;
    logic [lrsf_pkg::ROW_W-1:0] ld_row_b, first_b, last_b;
    logic                       marker_b;
    logic                       ld_col_end, ld_row_end, rd_col_end, rd_row_end;

    always_comb begin
        w = lrsf_pkg::clamp_dim(r_width, lrsf_pkg::MAX_W_DIM);
        h = lrsf_pkg::clamp_dim(r_height, lrsf_pkg::MAX_H_DIM);

        ld_col_b = r_complete ? '0 : r_ld_col;
        ld_row_b = r_complete ? '0 : r_ld_row;
        first_b  = r_complete ? '0 : r_span_first;
        last_b   = r_complete ? '0 : r_span_last;
        marker_b = r_complete ? 1'b0 : r_marker;

        ld_col_end = (lrsf_pkg::DIM_W'(ld_col_b) + lrsf_pkg::DIM_ONE) >= w;
        ld_row_end = (lrsf_pkg::DIM_W'(ld_row_b) + lrsf_pkg::DIM_ONE) >= h;
        rd_col_end = (lrsf_pkg::DIM_W'(r_rd_col) + lrsf_pkg::DIM_ONE) >= w;
        rd_row_end = (lrsf_pkg::DIM_W'(r_rd_row) + lrsf_pkg::DIM_ONE) >= h;

        n_width      = r_width;
        n_height     = r_height;
        n_ld_col     = r_ld_col;
        n_ld_row     = r_ld_row;
        n_rd_col     = r_rd_col;
        n_rd_row     = r_rd_row;
        n_span_first = r_span_first;
        n_span_last  = r_span_last;
        n_marker     = r_marker;
        n_complete   = r_complete;

        o_we    = 1'b0;
        o_waddr = {ld_row_b, ld_col_b};
        o_wdata = i_label;
        o_re    = 1'b0;
        o_raddr = {r_rd_row, r_rd_col};
        o_rd_info.in_span = r_marker && (r_rd_row >= r_span_first)
                            && (r_rd_row <= r_span_last);
        o_rd_info.last    = rd_col_end && rd_row_end;

        if (i_cfg_we) begin
            case (i_cfg_index)
                lrsf_pkg::CFG_FRAME_WIDTH:  n_width  = i_cfg_data;
                lrsf_pkg::CFG_FRAME_HEIGHT: n_height = i_cfg_data;
                default: ;
            endcase
            n_ld_col     = '0;
            n_ld_row     = '0;
            n_rd_col     = '0;
            n_rd_row     = '0;
            n_span_first = '0;
            n_span_last  = '0;
            n_marker     = 1'b0;
            n_complete   = 1'b0;
        end else if (i_accept && (i_action == lrsf_pkg::ACT_LOAD)) begin
            o_we         = 1'b1;
            n_span_first = first_b;
            n_span_last  = last_b;
            n_marker     = marker_b;
            n_complete   = 1'b0;
            if (r_complete) begin
                n_rd_col = '0;
                n_rd_row = '0;
            end
            if (i_label == lrsf_pkg::LABEL_MARK) begin
                if (!marker_b) begin
                    n_span_first = ld_row_b;
                end
                n_span_last = ld_row_b;
                n_marker    = 1'b1;
            end
            if (ld_col_end) begin
                n_ld_col = '0;
                if (ld_row_end) begin
                    n_ld_row   = '0;
                    n_complete = 1'b1;
                end else begin
                    n_ld_row = ld_row_b + lrsf_pkg::ROW_W'(1);
                end
            end else begin
                n_ld_col = ld_col_b + lrsf_pkg::COL_W'(1);
                n_ld_row = ld_row_b;
            end
        end else if (i_accept && r_complete) begin
            o_re = 1'b1;
            if (rd_col_end) begin
                n_rd_col = '0;
                n_rd_row = rd_row_end ? '0 : r_rd_row + lrsf_pkg::ROW_W'(1);
            end else begin
                n_rd_col = r_rd_col + lrsf_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= lrsf_pkg::DIM_RESET;
            r_height     <= lrsf_pkg::DIM_RESET;
            r_ld_col     <= '0;
            r_ld_row     <= '0;
            r_rd_col     <= '0;
            r_rd_row     <= '0;
            r_span_first <= '0;
            r_span_last  <= '0;
            r_marker     <= 1'b0;
            r_complete   <= 1'b0;
        end else begin
            r_width      <= n_width;
            r_height     <= n_height;
            r_ld_col     <= n_ld_col;
            r_ld_row     <= n_ld_row;
            r_rd_col     <= n_rd_col;
            r_rd_row     <= n_rd_row;
            r_span_first <= n_span_first;
            r_span_last  <= n_span_last;
            r_marker     <= n_marker;
            r_complete   <= n_complete;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lrsf_store.sv
// Frame store memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lrsf_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [lrsf_pkg::ADDR_W-1:0]   i_waddr,
    input  wire logic [lrsf_pkg::LABEL_W-1:0]  i_wdata,
    input  wire logic                          i_re,
    input  wire logic [lrsf_pkg::ADDR_W-1:0]   i_raddr,
    output logic [lrsf_pkg::LABEL_W-1:0]       o_rdata
);

    logic [lrsf_pkg::LABEL_W-1:0] r_mem [lrsf_pkg::DEPTH];
    logic [lrsf_pkg::LABEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/lrsf_out.sv
// Read tracking stage, relabelling and the output register.
`timescale 1ns / 1ps
`default_nettype none

module lrsf_out (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_re,
    input  wire lrsf_pkg::t_rd_info            i_rd_info,
    input  wire logic [lrsf_pkg::LABEL_W-1:0]  i_rdata,
    input  wire logic                          i_m_ready,
    output logic                               o_in_ready,
    output logic                               o_m_valid,
    output logic [lrsf_pkg::LABEL_W-1:0]       o_m_label,
    output logic                               o_m_last
);

    logic                         r_s1_valid, n_s1_valid;
    lrsf_pkg::t_rd_info           r_s1_info;
    logic                         r_out_valid, n_out_valid;
    logic [lrsf_pkg::LABEL_W-1:0] r_out_label, n_out_label;
    logic                         r_out_last;
    logic                         out_en;

    always_comb begin
        out_en      = !r_out_valid || i_m_ready;
        o_in_ready  = !r_s1_valid || out_en;
        n_s1_valid  = o_in_ready ? i_re : r_s1_valid;
        n_out_valid = out_en ? r_s1_valid : r_out_valid;

        if (i_rdata > lrsf_pkg::LABEL_MARK) begin
            n_out_label = lrsf_pkg::LABEL_ZERO;
        end else if ((i_rdata == lrsf_pkg::LABEL_ZERO) && r_s1_info.in_span) begin
            n_out_label = lrsf_pkg::LABEL_MARK;
        end else begin
            n_out_label = i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_s1_info <= i_rd_info;
        end
        if (out_en && r_s1_valid) begin
            r_out_label <= n_out_label;
            r_out_last  <= r_s1_info.last;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_label = r_out_label;
    assign o_m_last  = r_out_last;

endmodule

`default_nettype wire

>>> hw/rtl/label_row_span_fill_top.sv
// Top level of the label row span fill block.
// The block takes one transfer per clock cycle while s_tready is high, loads and
// reads alike, and keeps the whole frame in a 65536 by 8 bit store with one
// write port and one registered read port. A load writes one pixel and gives no
// result. A read after the frame is complete returns its relabelled pixel through
// the store read register and then the relabelling into the output register. A
// read before the frame is complete is taken and dropped. While a result waits in
// the output register, the tracking stage behind it keeps taking transfers until
// it holds a read; then s_tready stays low until the waiting result is taken. The
// rate is therefore one item per cycle while the downstream side keeps up.
// Configuration writes abandon the current frame.
`timescale 1ns / 1ps
`default_nettype none

module label_row_span_fill_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lrsf_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [lrsf_pkg::DIM_W-1:0]    i_cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] pixel_label
    input  wire logic                          s_tuser,  // [0] action
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,  // [7:0] result_label
    output logic                               m_tlast
);

    logic                         accept;
    logic                         we, re;
    logic [lrsf_pkg::ADDR_W-1:0]  waddr, raddr;
    logic [lrsf_pkg::LABEL_W-1:0] wdata, rdata;
    lrsf_pkg::t_rd_info           rd_info;

    assign accept = s_tvalid && s_tready;

    lrsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_action    (s_tuser),
        .i_label     (s_tdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_rd_info   (rd_info)
    );

    lrsf_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lrsf_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_re       (re),
        .i_rd_info  (rd_info),
        .i_rdata    (rdata),
        .i_m_ready  (m_tready),
        .o_in_ready (s_tready),
        .o_m_valid  (m_tvalid),
        .o_m_label  (m_tdata),
        .o_m_last   (m_tlast)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lrsf_check.sv
// Port level checks for the label row span fill block and their binding.
`timescale 1ns / 1ps
`default_nettype none

module lrsf_check (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_cfg_we,
    input wire logic [lrsf_pkg::IDX_W-1:0]  i_cfg_index,
    input wire logic [lrsf_pkg::DIM_W-1:0]  i_cfg_data,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [7:0]                  s_tdata,
    input wire logic                        s_tuser,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [7:0]                  m_tdata,
    input wire logic                        m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_label_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata <= lrsf_pkg::LABEL_MARK)
        else $error("result label above the marker label");

    a_rise_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == lrsf_pkg::ACT_READ), 2))
        else $error("result appeared without a read transfer two cycles earlier");

endmodule

bind label_row_span_fill_top lrsf_check u_check (.*);

`default_nettype wire

>>> sim/label_row_span_fill_top_tb.sv
// Self-checking testbench for the label row span fill block, with a scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] label;
    logic       is_last;
} t_pixel_result;

class label_span_board;
    bit [8:0]      width_reg;
    bit [8:0]      height_reg;
    bit [7:0]      frame_copy [0:65535];
    int            load_col;
    int            load_row;
    int            read_col;
    int            read_row;
    int            span_top;
    int            span_bottom;
    bit            marker_seen;
    bit            frame_loaded;
    t_pixel_result awaited [$];
    int            mismatches;
    int            loads_seen;
    int            results_checked;

    function new();
        width_reg       = 9'd256;
        height_reg      = 9'd256;
        mismatches      = 0;
        loads_seen      = 0;
        results_checked = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        load_col     = 0;
        load_row     = 0;
        read_col     = 0;
        read_row     = 0;
        span_top     = 0;
        span_bottom  = 0;
        marker_seen  = 1'b0;
        frame_loaded = 1'b0;
    endfunction

    function int dim_in_use(bit [8:0] value, int limit);
        if (value == 0) begin
            return 1;
        end
        if (value > limit) begin
            return limit;
        end
        return value;
    endfunction

    function int frame_pixels();
        return dim_in_use(width_reg, lrsf_pkg::MAX_WIDTH)
               * dim_in_use(height_reg, lrsf_pkg::MAX_HEIGHT);
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction

    function void write_reg(logic [lrsf_pkg::IDX_W-1:0] index, bit [8:0] value);
        if (index == lrsf_pkg::CFG_FRAME_WIDTH) begin
            width_reg = value;
        end else begin
            height_reg = value;
        end
        restart_frame();
    endfunction

    // Returns 1 when the transfer is a load or a read that yields a pixel.
    function bit note_transfer(logic action, logic [7:0] lbl);
        int            w;
        int            h;
        bit [7:0]      stored;
        t_pixel_result px;
        w = dim_in_use(width_reg, lrsf_pkg::MAX_WIDTH);
        h = dim_in_use(height_reg, lrsf_pkg::MAX_HEIGHT);
        if (action == lrsf_pkg::ACT_LOAD) begin
            if (frame_loaded) begin
                restart_frame();
            end
            frame_copy[load_row * lrsf_pkg::MAX_WIDTH + load_col] = lbl;
            if (lbl == lrsf_pkg::LABEL_MARK) begin
                if (!marker_seen) begin
                    span_top    = load_row;
                    marker_seen = 1'b1;
                end
                span_bottom = load_row;
            end
            if (load_col + 1 >= w) begin
                load_col = 0;
                if (load_row + 1 >= h) begin
                    load_row     = 0;
                    frame_loaded = 1'b1;
                end else begin
                    load_row++;
                end
            end else begin
                load_col++;
            end
            loads_seen++;
            return 1'b1;
        end
        if (!frame_loaded) begin
            return 1'b0;
        end
        stored     = frame_copy[read_row * lrsf_pkg::MAX_WIDTH + read_col];
        px.is_last = (read_col + 1 >= w) && (read_row + 1 >= h);
        if (stored > lrsf_pkg::LABEL_MARK) begin
            px.label = lrsf_pkg::LABEL_ZERO;
        end else if (stored == lrsf_pkg::LABEL_ZERO && marker_seen
                     && read_row >= span_top && read_row <= span_bottom) begin
            px.label = lrsf_pkg::LABEL_MARK;
        end else begin
            px.label = stored;
        end
        awaited.push_back(px);
        if (read_col + 1 >= w) begin
            read_col = 0;
            read_row = (read_row + 1 >= h) ? 0 : read_row + 1;
        end else begin
            read_col++;
        end
        return 1'b1;
    endfunction

    function void check_result(logic [7:0] lbl, logic is_last);
        t_pixel_result px;
        if (awaited.size() == 0) begin
            $error("unexpected transfer: result_label %0d, last_pixel %0d", lbl, is_last);
            mismatches++;
            return;
        end
        px = awaited.pop_front();
        results_checked++;
        if (lbl !== px.label) begin
            $error("result_label: expected %0d, got %0d", px.label, lbl);
            mismatches++;
        end
        if (is_last !== px.is_last) begin
            $error("last_pixel: expected %0d, got %0d", px.is_last, is_last);
            mismatches++;
        end
    endfunction
endclass

module label_row_span_fill_top_tb;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 6;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [lrsf_pkg::IDX_W-1:0]    i_cfg_index;
    logic [lrsf_pkg::DIM_W-1:0]    i_cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;   // [7:0] pixel_label
    logic                          s_tuser;   // [0] action
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [7:0]                    m_tdata;   // [7:0] result_label
    logic                          m_tlast;

    label_span_board board;
    int              idle_pct = 0;
    int              stall_pct = 0;
    int              useful_items = 0;
    int              settings_used = 0;

    label_row_span_fill_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tlast);
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 14; stall_pct = 14; end
        endcase
    endtask

    // Called and returns at a falling edge; the valid stays high for a following transfer.
    task automatic send_item(input logic action, input logic [7:0] lbl);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= lbl;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        if (board.note_transfer(action, lbl)) begin
            useful_items++;
        end
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained(input int settle);
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (board.outstanding() != 0) begin
            @(negedge i_clk);
        end
        repeat (settle) @(negedge i_clk);
    endtask

    // which: 0 writes the width only, 1 the height only, otherwise both.
    task automatic configure(input bit [8:0] w, input bit [8:0] h, input int which);
        if (which != 1) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= lrsf_pkg::CFG_FRAME_WIDTH;
            i_cfg_data  <= w;
            @(negedge i_clk);
            board.write_reg(lrsf_pkg::CFG_FRAME_WIDTH, w);
        end
        if (which != 0) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= lrsf_pkg::CFG_FRAME_HEIGHT;
            i_cfg_data  <= h;
            @(negedge i_clk);
            board.write_reg(lrsf_pkg::CFG_FRAME_HEIGHT, h);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // A zero mark_div keeps the marker label out of the frame altogether.
    function automatic logic [7:0] pick_label(input int mark_div);
        int         k;
        logic [7:0] v;
        k = $urandom_range(0, 15);
        if (mark_div != 0 && $urandom_range(0, mark_div - 1) == 0) begin
            return lrsf_pkg::LABEL_MARK;
        end
        if (k < 6) begin
            v = lrsf_pkg::LABEL_ZERO;
        end else if (k < 8) begin
            v = 8'd1;
        end else begin
            v = 8'($urandom);
        end
        if (v == lrsf_pkg::LABEL_MARK && mark_div == 0) begin
            v = lrsf_pkg::LABEL_ZERO;
        end
        return v;
    endfunction

    initial begin
        int         phase;
        int         frame;
        int         frames;
        int         i;
        int         pixels;
        int         n_px;
        int         n_reads;
        int         mark_div;
        int         which;
        bit [8:0]   new_w;
        bit [8:0]   new_h;
        bit         broken;
        bit         pause_mid;
        s_tvalid    = 1'b0;
        s_tuser     = lrsf_pkg::ACT_LOAD;
        s_tdata     = 8'd0;
        i_cfg_we    = 1'b0;
        i_cfg_index = lrsf_pkg::CFG_FRAME_WIDTH;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        board       = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Early read at reset size is dropped; the partial load is then abandoned.
        set_idling(0);
        send_item(lrsf_pkg::ACT_READ, 8'hA5);
        send_item(lrsf_pkg::ACT_LOAD, 8'd255);
        hold_until_drained(DRAIN_CYCLES);

        // Two by three frame with the marker on the middle row only.
        configure(9'd2, 9'd3, 2);
        send_item(lrsf_pkg::ACT_LOAD, 8'd0);
        send_item(lrsf_pkg::ACT_LOAD, 8'd3);
        send_item(lrsf_pkg::ACT_READ, 8'h5A);
        send_item(lrsf_pkg::ACT_LOAD, lrsf_pkg::LABEL_MARK);
        send_item(lrsf_pkg::ACT_LOAD, 8'd0);
        send_item(lrsf_pkg::ACT_LOAD, 8'd0);
        send_item(lrsf_pkg::ACT_LOAD, 8'd255);
        for (i = 0; i < 3; i++) begin
            send_item(lrsf_pkg::ACT_READ, 8'hFF);
        end
        hold_until_drained(0);
        for (i = 0; i < 4; i++) begin
            send_item(lrsf_pkg::ACT_READ, 8'h00);
        end
        // Loading in the read phase starts a fresh frame, this one without a marker.
        send_item(lrsf_pkg::ACT_LOAD, 8'd0);
        send_item(lrsf_pkg::ACT_LOAD, 8'd1);
        send_item(lrsf_pkg::ACT_LOAD, 8'd0);
        send_item(lrsf_pkg::ACT_LOAD, 8'd1);
        send_item(lrsf_pkg::ACT_LOAD, 8'd3);
        send_item(lrsf_pkg::ACT_LOAD, 8'd0);
        for (i = 0; i < 6; i++) begin
            send_item(lrsf_pkg::ACT_READ, 8'h00);
        end
        hold_until_drained(DRAIN_CYCLES);

        // Every idling mode gets at least one phase; large frames get a single pass.
        useful_items = 0;
        phase = 0;
        while (useful_items < RANDOM_ITEMS || phase < 4) begin
            set_idling(phase % 4);
            which = 2;
            case (phase)
                0: begin new_w = 9'd511; new_h = 9'd0;   end
                2: begin new_w = 9'd0;   new_h = 9'd300; end
                3: begin new_w = 9'd0;   new_h = 9'd0;   end
                default: begin
                    new_w = 9'($urandom_range(1, 9));
                    new_h = 9'($urandom_range(1, 9));
                    which = $urandom_range(0, 3);
                    if (which > 2) begin
                        which = 2;
                    end
                end
            endcase
            configure(new_w, new_h, which);
            pixels = board.frame_pixels();
            frames = (pixels > 100) ? 1 : $urandom_range(1, 3);
            for (frame = 0; frame < frames; frame++) begin
                case ($urandom_range(0, 2))
                    0: mark_div = 0;
                    1: mark_div = 4;
                    default: mark_div = 24;
                endcase
                broken = ($urandom_range(0, 7) == 0);
                n_px   = broken ? $urandom_range(0, pixels - 1) : pixels;
                for (i = 0; i < n_px; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(lrsf_pkg::ACT_READ, 8'($urandom));
                    end
                    send_item(lrsf_pkg::ACT_LOAD, pick_label(mark_div));
                end
                if (broken) begin
                    break;
                end
                if ($urandom_range(0, 3) == 0) begin
                    n_reads = $urandom_range(1, pixels);
                end else begin
                    n_reads = pixels + $urandom_range(0, 3);
                end
                pause_mid = ($urandom_range(0, 3) == 0);
                for (i = 0; i < n_reads; i++) begin
                    if (pause_mid && i == n_reads / 2) begin
                        hold_until_drained(0);
                    end
                    send_item(lrsf_pkg::ACT_READ, 8'($urandom));
                end
            end
            hold_until_drained(DRAIN_CYCLES);
            phase++;
        end

        $display("Run covered %0d register settings, %0d pixel loads",
                 settings_used, board.loads_seen);
        $display("and %0d relabelled pixels over all idling modes.", board.results_checked);
        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
